// ----- rtl/core/bmfd_pkg.sv -----
// ----------------------------------------------------------------------------
// bmfd_pkg
// Shared types, constants and helpers of the block-mean motion detector.
// ----------------------------------------------------------------------------
package bmfd_pkg;

    localparam int LUMA_W     = 8;
    localparam int PIX_W      = 11;   // pixel column / row counters
    localparam int BLK_SHIFT  = 4;    // 16x16 blocks
    localparam int BLK_OFS_W  = 4;
    localparam int ACC_W      = 11;   // eight even pixels of one block line
    localparam int SUM_W      = 14;   // 64 sampled pixels
    localparam int MEAN_W     = 8;
    localparam int DIFF_W     = 8;
    localparam int THR_W      = 17;
    localparam int CNT_W      = 15;
    localparam int GDIM_W     = 9;    // grid columns / rows, up to 256
    localparam int IDX_W      = 16;   // block index into the grid store
    localparam int FRAC_W     = 16;   // Q0.16 ratio
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    localparam logic [BLK_OFS_W-1:0] BLK_LAST  = 4'd15;
    localparam logic [PIX_W-1:0]     ROW_LIMIT = 11'd2047;
    localparam logic [CNT_W-1:0]     CNT_MAX   = 15'h7FFF;
    localparam logic [GDIM_W-1:0]    MIN_GRID  = 9'd2;

    localparam logic [DIFF_W-1:0] DIFF_LEVEL_RST = 8'd16;
    localparam logic [THR_W-1:0]  RATIO_THR_RST  = 17'd1311;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENGINE_ENABLE = 3'd0,
        CFG_FRAME_WIDTH   = 3'd1,
        CFG_FRAME_HEIGHT  = 3'd2,
        CFG_DIFF_LEVEL    = 3'd3,
        CFG_RATIO_THR     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic              engine_enable;
        logic [PIX_W-1:0]  frame_width;
        logic [PIX_W-1:0]  frame_height;
        logic [DIFF_W-1:0] diff_level;
        logic [THR_W-1:0]  ratio_threshold_q16;
    } t_cfg;

    // One queue entry: a finished block, a frame end, or both on one pixel.
    typedef struct packed {
        logic              blk;
        logic [MEAN_W-1:0] mean;
        logic [IDX_W-1:0]  idx;
        logic              fend;
        logic              runs;
        logic [GDIM_W-1:0] gw;
        logic [GDIM_W-1:0] gh;
    } t_evt;

    // Blocks along one dimension, clamped to the store's limit.
    function automatic logic [GDIM_W-1:0] grid_dim(input logic [PIX_W-1:0] dim,
                                                   input logic [GDIM_W-1:0] max_dim);
        logic [GDIM_W-1:0] raw;
        raw = GDIM_W'(dim[PIX_W-1:BLK_SHIFT]);
        return (raw > max_dim) ? max_dim : raw;
    endfunction

endpackage

// ----- rtl/core/bmfd_front.sv -----
// ----------------------------------------------------------------------------
// bmfd_front
// Pixel position tracking, per-column block sums and block/frame events.
// ----------------------------------------------------------------------------
module bmfd_front #(
    parameter int MAX_GRID_COLS = 128,
    parameter int MAX_GRID_ROWS = 128
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bmfd_pkg::t_cfg               i_cfg,
    input  logic                         i_pix_acc,
    input  logic [bmfd_pkg::LUMA_W-1:0]  i_luma,
    input  logic                         i_frame_end,
    output logic                         o_evt_push,
    output bmfd_pkg::t_evt               o_evt
);
    import bmfd_pkg::*;

    localparam int RS_AW = $clog2(MAX_GRID_COLS);

    logic [GDIM_W-1:0]    gw, gh, bc, br;
    logic [BLK_OFS_W-1:0] co, ro;
    logic                 runs, in_grid, even_pos, line_end, blk_done;
    logic [SUM_W-1:0]     rsum_wr;
    logic [PIX_W-1:0]     n_col, n_row;
    logic [IDX_W-1:0]     n_row_base;

    logic [PIX_W-1:0]     r_col, r_row;
    logic [IDX_W-1:0]     r_row_base;
    logic [ACC_W-1:0]     r_acc;
    logic [SUM_W-1:0]     r_rsum_rd;
    logic [SUM_W-1:0]     r_rsum_mem [MAX_GRID_COLS];

    always_comb begin
        gw       = grid_dim(i_cfg.frame_width,  GDIM_W'(MAX_GRID_COLS));
        gh       = grid_dim(i_cfg.frame_height, GDIM_W'(MAX_GRID_ROWS));
        bc       = GDIM_W'(r_col[PIX_W-1:BLK_SHIFT]);
        br       = GDIM_W'(r_row[PIX_W-1:BLK_SHIFT]);
        co       = r_col[BLK_OFS_W-1:0];
        ro       = r_row[BLK_OFS_W-1:0];
        runs     = i_cfg.engine_enable && (gw >= MIN_GRID) && (gh >= MIN_GRID);
        in_grid  = runs && (bc < gw) && (br < gh);
        even_pos = !co[0] && !ro[0];
        blk_done = in_grid && (co == BLK_LAST) && (ro == BLK_LAST);
        // close one block line: top line starts fresh, others add to stored sum
        rsum_wr  = ((ro == '0) ? '0 : r_rsum_rd) + SUM_W'(r_acc);
        line_end = ({1'b0, r_col} + (PIX_W+1)'(1)) >= {1'b0, i_cfg.frame_width};

        n_col      = r_col + PIX_W'(1);
        n_row      = r_row;
        n_row_base = r_row_base;
        if (i_frame_end) begin
            n_col      = '0;
            n_row      = '0;
            n_row_base = '0;
        end else if (line_end) begin
            n_col = '0;
            if (r_row < ROW_LIMIT) begin
                n_row = r_row + PIX_W'(1);
                if ((ro == BLK_LAST) && (br < gh)) begin
                    n_row_base = r_row_base + IDX_W'(gw);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_row_base <= '0;
        end else if (i_pix_acc) begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_row_base <= n_row_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix_acc && in_grid && even_pos) begin
            r_acc <= ((co == '0) ? '0 : r_acc) + ACC_W'(i_luma);
        end
    end

    // column sums: read at the current block column every cycle
    always_ff @(posedge i_clk) begin
        if (i_pix_acc && in_grid && (co == BLK_LAST) && !ro[0]) begin
            r_rsum_mem[bc[RS_AW-1:0]] <= rsum_wr;
        end
        r_rsum_rd <= r_rsum_mem[bc[RS_AW-1:0]];
    end

    always_comb begin
        o_evt_push = i_pix_acc && (blk_done || i_frame_end);
        o_evt.blk  = blk_done;
        o_evt.mean = r_rsum_rd[SUM_W-1:SUM_W-MEAN_W];
        o_evt.idx  = r_row_base + IDX_W'(bc);
        o_evt.fend = i_frame_end;
        o_evt.runs = runs;
        o_evt.gw   = gw;
        o_evt.gh   = gh;
    end

endmodule

// ----- rtl/core/bmfd_queue.sv -----
// ----------------------------------------------------------------------------
// bmfd_queue
// Short event queue between the pixel front and the grid back end.
// ----------------------------------------------------------------------------
module bmfd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bmfd_pkg::t_evt  i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output bmfd_pkg::t_evt  o_data
);
    import bmfd_pkg::*;

    t_evt               r_slot [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, r_rptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_full  = (r_count == Q_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");

endmodule

// ----- rtl/core/bmfd_back.sv -----
// ----------------------------------------------------------------------------
// bmfd_back
// Grid store compare/update, changed-block count and frame decision.
// ----------------------------------------------------------------------------
module bmfd_back #(
    parameter int MAX_GRID_COLS = 128,
    parameter int MAX_GRID_ROWS = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bmfd_pkg::t_cfg  i_cfg,
    input  logic            i_evt_valid,
    input  bmfd_pkg::t_evt  i_evt,
    output logic            o_evt_pop,
    output logic            o_tvalid,
    input  logic            i_tready,
    output logic            o_motion,
    output logic            o_changed
);
    import bmfd_pkg::*;

    localparam int GRID_DEPTH = MAX_GRID_COLS * MAX_GRID_ROWS;
    localparam int GRID_AW    = $clog2(GRID_DEPTH);
    localparam int CELLS_W    = 2 * GDIM_W;
    localparam int RHS_W      = THR_W + CELLS_W;

    logic [GDIM_W-1:0]  gw, gh;
    logic               out_free, s1_adv, same_grid, blk_changed, detected, flipped;
    logic [MEAN_W-1:0]  mean_diff;
    logic [CNT_W-1:0]   n_changed;
    logic [RHS_W-1:0]   lhs;

    logic               r_s1_v;
    t_evt               r_s1;
    logic [MEAN_W-1:0]  r_old;
    logic [GDIM_W-1:0]  r_prev_cols, r_prev_rows;
    logic [CNT_W-1:0]   r_changed;
    logic               r_last;
    logic [CELLS_W-1:0] r_cells;
    logic [RHS_W-1:0]   r_rhs;
    logic               r_out_v, r_out_md, r_out_sc;
    logic [MEAN_W-1:0]  r_grid_mem [GRID_DEPTH];

    always_comb begin
        gw          = grid_dim(i_cfg.frame_width,  GDIM_W'(MAX_GRID_COLS));
        gh          = grid_dim(i_cfg.frame_height, GDIM_W'(MAX_GRID_ROWS));
        out_free    = !r_out_v || i_tready;
        // a frame-end entry waits for the output register; block-only ones never
        s1_adv      = r_s1_v && (!r_s1.fend || out_free);
        o_evt_pop   = i_evt_valid && (!r_s1_v || s1_adv);
        same_grid   = (r_prev_cols == r_s1.gw) && (r_prev_rows == r_s1.gh);
        mean_diff   = (r_s1.mean > r_old) ? (r_s1.mean - r_old) : (r_old - r_s1.mean);
        blk_changed = r_s1.blk && same_grid && (mean_diff > i_cfg.diff_level)
                      && (r_changed != CNT_MAX);
        n_changed   = blk_changed ? (r_changed + CNT_W'(1)) : r_changed;
        lhs         = RHS_W'({n_changed, {FRAC_W{1'b0}}});
        detected    = (r_s1.runs && same_grid) ? (lhs > r_rhs) : r_last;
        flipped     = r_s1.runs && (detected != r_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_prev_cols <= '0;
            r_prev_rows <= '0;
            r_changed   <= '0;
            r_last      <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            if (o_evt_pop) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                if (r_s1.fend) begin
                    r_changed <= '0;
                    if (r_s1.runs) begin
                        r_prev_cols <= r_s1.gw;
                        r_prev_rows <= r_s1.gh;
                        r_last      <= detected;
                    end
                end else begin
                    r_changed <= n_changed;
                end
            end
            if (s1_adv && r_s1.fend) begin
                r_out_v <= 1'b1;
            end else if (i_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_evt_pop) begin
            r_s1 <= i_evt;
        end
        if (s1_adv && r_s1.fend) begin
            r_out_md <= detected;
            r_out_sc <= flipped;
        end
        // threshold side of the ratio compare follows the registers
        r_cells <= gw * gh;
        r_rhs   <= RHS_W'(i_cfg.ratio_threshold_q16) * RHS_W'(r_cells);
    end

    // previous-frame means: read on pop, written when the block retires
    always_ff @(posedge i_clk) begin
        if (o_evt_pop) begin
            r_old <= r_grid_mem[i_evt.idx[GRID_AW-1:0]];
        end
        if (s1_adv && r_s1.blk) begin
            r_grid_mem[r_s1.idx[GRID_AW-1:0]] <= r_s1.mean;
        end
    end

    assign o_tvalid  = r_out_v;
    assign o_motion  = r_out_md;
    assign o_changed = r_out_sc;

    a_flip_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_sc) |-> (r_out_md == r_last))
        else $error("flip flag disagrees with stored motion state");

    a_block_only_when_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_s1.blk) |-> r_s1.runs)
        else $error("block entry while engine idle");

endmodule

// ----- rtl/core/block_mean_frame_difference_motion_unit.sv -----
// ----------------------------------------------------------------------------
// block_mean_frame_difference_motion_unit
// Frame-difference motion detector on 16x16 block means of a luma stream.
// ----------------------------------------------------------------------------
// Pixels enter on s_axis in raster order, one per clock, with s_axis_tlast on
// the last pixel of a frame. The front tracks the pixel position, sums the
// even-offset pixels of each 16x16 block per grid column and, when a block
// completes, queues its mean and grid index; the back compares it with the
// stored mean of the previous frame and counts blocks whose change exceeds
// diff_level. On every frame end one item leaves on m_axis with the motion
// state and a flip flag. Sustained rate is one pixel per cycle: s_axis_tready
// drops only when the four-entry event queue fills, which takes a result held
// on m_axis while further block events arrive (at most one per 16 pixels).
// A frame result is registered in the event queue and the back end's entry
// and output registers. The grid store is one single-port-per-side memory of
// MAX_GRID_COLS*MAX_GRID_ROWS bytes with a registered read, one read-modify-
// write per block. Partial edge blocks, grids under 2x2 blocks and a cleared
// engine_enable store nothing; a new grid size primes the store without a
// decision. Write configuration only while no frame is in flight.
module block_mean_frame_difference_motion_unit #(
    parameter int MAX_GRID_COLS = 128,
    parameter int MAX_GRID_ROWS = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [bmfd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bmfd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // pixel stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bmfd_pkg::TDATA_IN_W-1:0]   s_axis_tdata,   // [7:0] luma
    input  logic                              s_axis_tlast,   // frame_end
    // frame results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bmfd_pkg::TDATA_OUT_W-1:0]  m_axis_tdata    // [0] motion_detected,
                                                              // [1] state_changed, [7:2] 0
);
    import bmfd_pkg::*;

    t_cfg  r_cfg;
    logic  pix_acc, evt_push, q_full, q_valid, q_pop, res_md, res_sc;
    t_evt  evt_in, evt_out;

    // register file: writes to unused indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.engine_enable       <= 1'b0;
            r_cfg.frame_width         <= '0;
            r_cfg.frame_height        <= '0;
            r_cfg.diff_level          <= DIFF_LEVEL_RST;
            r_cfg.ratio_threshold_q16 <= RATIO_THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENGINE_ENABLE: r_cfg.engine_enable       <= i_cfg_data[0];
                CFG_FRAME_WIDTH:   r_cfg.frame_width         <= i_cfg_data[PIX_W-1:0];
                CFG_FRAME_HEIGHT:  r_cfg.frame_height        <= i_cfg_data[PIX_W-1:0];
                CFG_DIFF_LEVEL:    r_cfg.diff_level          <= i_cfg_data[DIFF_W-1:0];
                CFG_RATIO_THR:     r_cfg.ratio_threshold_q16 <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // hold pixels only while the event queue has no room
    assign s_axis_tready = !q_full;
    assign pix_acc       = s_axis_tvalid && s_axis_tready;

    bmfd_front #(
        .MAX_GRID_COLS (MAX_GRID_COLS),
        .MAX_GRID_ROWS (MAX_GRID_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pix_acc   (pix_acc),
        .i_luma      (s_axis_tdata[LUMA_W-1:0]),
        .i_frame_end (s_axis_tlast),
        .o_evt_push  (evt_push),
        .o_evt       (evt_in)
    );

    bmfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (evt_push),
        .i_data  (evt_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (evt_out)
    );

    bmfd_back #(
        .MAX_GRID_COLS (MAX_GRID_COLS),
        .MAX_GRID_ROWS (MAX_GRID_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_evt_valid (q_valid),
        .i_evt       (evt_out),
        .o_evt_pop   (q_pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_motion    (res_md),
        .o_changed   (res_sc)
    );

    assign m_axis_tdata = {(TDATA_OUT_W-2)'(0), res_sc, res_md};

endmodule
